### sv/task_semaphore_wait_unit_macros.svh
// Assertion macros for the task semaphore wait unit.
`ifndef TASK_SEMAPHORE_WAIT_UNIT_MACROS_SVH
`define TASK_SEMAPHORE_WAIT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define TSWU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Implication check failed.");

`define TSWU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("Forbidden condition seen.");

`else

`define TSWU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TSWU_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### sv/tswu_pkg.sv
// Types and constants shared by the task semaphore wait unit.
package tswu_pkg;

    localparam int NUM_SEMAPHORES_DEF = 8;
    localparam int TIMER_BITS_DEF     = 16;

    localparam int WAIT_TICKS_W = 16;
    localparam int SEM_INDEX_W  = 4;
    localparam int SEM_COUNT_W  = 8;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 8;

    localparam logic [SEM_COUNT_W-1:0] SEM_COUNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_TIMED_WAIT = 3'd1,
        ACT_SIGNAL     = 3'd2,
        ACT_WAIT       = 3'd3,
        ACT_CHECK      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        COND_READY   = 2'd0,
        COND_TIMEOUT = 2'd1,
        COND_SEM     = 2'd2
    } cond_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TIMEOUT = 2'd1,
        EV_SIGNAL  = 2'd2
    } event_t;

    typedef struct packed {
        logic [WAIT_TICKS_W-1:0] wait_ticks;
        logic [SEM_INDEX_W-1:0]  sem_index;
        logic [2:0]              action;
    } item_t;

    typedef struct packed {
        logic   run_now;
        logic   granted;
        event_t last_event;
        cond_t  task_condition;
    } result_t;

endpackage

### sv/tswu_in_stage.sv
// Input register stage of the task semaphore wait unit.
module tswu_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  tswu_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output tswu_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    tswu_pkg::item_t item_reg;
    logic            s_fire;

    assign s_tready = !valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/tswu_exec.sv
// Task condition, wait timer and semaphore bank with the per-word update logic.
module tswu_exec #(
    parameter int NUM_SEMAPHORES = tswu_pkg::NUM_SEMAPHORES_DEF,
    parameter int TIMER_BITS     = tswu_pkg::TIMER_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  tswu_pkg::item_t  item,
    output tswu_pkg::result_t result
);

    localparam int SEM_IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam logic [tswu_pkg::SEM_INDEX_W:0] NUM_SEM_LIM =
        (tswu_pkg::SEM_INDEX_W+1)'(NUM_SEMAPHORES);

    tswu_pkg::cond_t  cond_reg, cond_next;
    tswu_pkg::event_t event_reg, event_next;
    logic [TIMER_BITS-1:0] counter_reg, counter_next;
    logic [SEM_IDX_W-1:0]  awaited_reg, awaited_next;
    logic [tswu_pkg::SEM_COUNT_W-1:0] sem_reg [NUM_SEMAPHORES];

    tswu_pkg::action_t action;
    logic                 idx_ok;
    logic                 addr_ok;
    logic [SEM_IDX_W-1:0] req_idx;
    logic [SEM_IDX_W-1:0] addr;
    logic [tswu_pkg::SEM_COUNT_W-1:0] sem_val;
    logic [tswu_pkg::SEM_COUNT_W-1:0] sem_wdata;
    logic                 sem_write;
    logic [TIMER_BITS-1:0] load_val;
    logic [TIMER_BITS-1:0] counter_dec;
    logic                 granted;
    logic                 run_now;

    generate
        if (TIMER_BITS > tswu_pkg::WAIT_TICKS_W) begin : g_load_wide
            assign load_val = {{(TIMER_BITS - tswu_pkg::WAIT_TICKS_W){1'b0}}, item.wait_ticks};
        end else if (TIMER_BITS == tswu_pkg::WAIT_TICKS_W) begin : g_load_equal
            assign load_val = item.wait_ticks;
        end else begin : g_load_narrow
            assign load_val = item.wait_ticks[TIMER_BITS-1:0];
        end
    endgenerate

    assign action      = tswu_pkg::action_t'(item.action);
    assign idx_ok      = {1'b0, item.sem_index} < NUM_SEM_LIM;
    assign req_idx     = item.sem_index[SEM_IDX_W-1:0];
    assign addr        = (action == tswu_pkg::ACT_TICK) ? awaited_reg : req_idx;
    assign addr_ok     = (action == tswu_pkg::ACT_TICK) ? 1'b1 : idx_ok;
    assign sem_val     = addr_ok ? sem_reg[addr] : '0;
    assign counter_dec = counter_reg - TIMER_BITS'(1);

    always_comb begin
        cond_next    = cond_reg;
        event_next   = event_reg;
        counter_next = counter_reg;
        awaited_next = awaited_reg;
        sem_write    = 1'b0;
        sem_wdata    = sem_val - 8'd1;
        granted      = 1'b0;
        run_now      = 1'b0;
        unique case (action)
            tswu_pkg::ACT_TICK: begin
                if (cond_reg == tswu_pkg::COND_TIMEOUT) begin
                    counter_next = counter_dec;
                    if (counter_dec == '0) begin
                        cond_next  = tswu_pkg::COND_READY;
                        event_next = tswu_pkg::EV_TIMEOUT;
                    end
                end
                if (cond_reg == tswu_pkg::COND_SEM && sem_val != '0) begin
                    sem_write  = 1'b1;
                    cond_next  = tswu_pkg::COND_READY;
                    event_next = tswu_pkg::EV_SIGNAL;
                end
                run_now = (cond_next == tswu_pkg::COND_READY);
            end
            tswu_pkg::ACT_TIMED_WAIT: begin
                counter_next = load_val;
                cond_next    = tswu_pkg::COND_TIMEOUT;
            end
            tswu_pkg::ACT_SIGNAL: begin
                sem_wdata = sem_val + 8'd1;
                sem_write = idx_ok && (sem_val != tswu_pkg::SEM_COUNT_MAX);
            end
            tswu_pkg::ACT_WAIT: begin
                if (idx_ok) begin
                    if (sem_val != '0) begin
                        sem_write = 1'b1;
                        cond_next = tswu_pkg::COND_READY;
                        granted   = 1'b1;
                    end else begin
                        awaited_next = req_idx;
                        cond_next    = tswu_pkg::COND_SEM;
                    end
                end
            end
            tswu_pkg::ACT_CHECK: begin
                if (idx_ok && sem_val != '0) begin
                    sem_write = 1'b1;
                    granted   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond_reg    <= tswu_pkg::COND_READY;
            event_reg   <= tswu_pkg::EV_NONE;
            counter_reg <= '0;
            awaited_reg <= '0;
        end else if (fire) begin
            cond_reg    <= cond_next;
            event_reg   <= event_next;
            counter_reg <= counter_next;
            awaited_reg <= awaited_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SEMAPHORES; i++) begin
                sem_reg[i] <= '0;
            end
        end else if (fire && sem_write) begin
            sem_reg[addr] <= sem_wdata;
        end
    end

    assign result.task_condition = cond_next;
    assign result.last_event     = event_next;
    assign result.granted        = granted;
    assign result.run_now        = run_now;

endmodule

### sv/tswu_out_stage.sv
// Result register stage of the task semaphore wait unit.
module tswu_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    output logic              can_load,
    input  tswu_pkg::result_t result,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tswu_pkg::result_t m_result
);

    logic              valid_reg;
    logic              valid_next;
    tswu_pkg::result_t result_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

### sv/task_semaphore_wait_unit.sv
// Top level of the task semaphore wait unit.
// Each input word is one action (tick, timed wait, signal, blocking wait or check) on
// one task's wait condition and a bank of 8-bit counting semaphores, and each word gives
// exactly one result word. The unit takes one word per clock cycle while the result register is not
// stalled: the word is registered, the condition, timer and semaphore read-modify-write are done
// combinationally on the registered word, and the result is registered.
// A stalled result register holds the input register, which in turn holds s_tready low.
// All control state, including the semaphore counts, is cleared by reset; the data registers are not.
`include "task_semaphore_wait_unit_macros.svh"

module task_semaphore_wait_unit #(
    parameter int NUM_SEMAPHORES = tswu_pkg::NUM_SEMAPHORES_DEF,
    parameter int TIMER_BITS     = tswu_pkg::TIMER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: action[2:0], sem_index[6:3], wait_ticks[22:7], zero pad[23].
    input  logic [tswu_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: task_condition[1:0], last_event[3:2], granted[4], run_now[5],
    // zero pad[7:6].
    output logic [tswu_pkg::M_TDATA_W-1:0] m_tdata
);

    tswu_pkg::item_t   s_item;
    tswu_pkg::item_t   item;
    tswu_pkg::result_t result;
    tswu_pkg::result_t m_result;
    logic              item_valid;
    logic              can_load;
    logic              fire;

    assign s_item = s_tdata[$bits(tswu_pkg::item_t)-1:0];
    assign fire   = item_valid && can_load;

    tswu_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    tswu_exec #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .TIMER_BITS     (TIMER_BITS)
    ) u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    tswu_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .can_load (can_load),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{(tswu_pkg::M_TDATA_W - $bits(tswu_pkg::result_t)){1'b0}}, m_result};

    `TSWU_ASSERT_NEVER(a_grant_and_run, aclk, aresetn, m_tvalid && m_result.granted && m_result.run_now)
    `TSWU_ASSERT_IMPLIES(a_run_means_ready, aclk, aresetn, m_tvalid && m_result.run_now, m_result.task_condition == tswu_pkg::COND_READY)
    `TSWU_ASSERT_IMPLIES(a_stall_backs_up, aclk, aresetn, item_valid && m_tvalid && !m_tready, !s_tready)

endmodule
